>>> rtl/bc_pkg.sv
// ----------------------------------------------------------------------------
// bc_pkg
// shared types and constants of the barometer compensation pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package bc_pkg;

  // configuration register indexes
  typedef enum logic [7:0] {
    BC_REG_CAL_TEMP   = 8'd0,
    BC_REG_CAL_PRES_A = 8'd1,
    BC_REG_CAL_PRES_B = 8'd2,
    BC_REG_OSS        = 8'd3
  } bc_reg_t;

  localparam int BC_CFG_IDX_W  = 8;
  localparam int BC_CFG_DATA_W = 64;

  // word packing
  localparam int BC_UT_W    = 16;
  localparam int BC_UP_W    = 19;
  localparam int BC_TEMP_W  = 16;
  localparam int BC_PRES_W  = 18;
  localparam int BC_IN_W    = 40;
  localparam int BC_OUT_W   = 40;

  // divider geometry: temperature step and pressure step
  localparam int BC_DIV_T_NUM_W = 27;
  localparam int BC_DIV_T_DEN_W = 18;
  localparam int BC_DIV_P_NUM_W = 32;
  localparam int BC_DIV_P_DEN_W = 33;

  // compensation constants
  localparam int unsigned BC_B6_OFFSET   = 4000;
  localparam int unsigned BC_X3_OFFSET   = 32768;
  localparam int unsigned BC_P_FACTOR    = 50000;
  localparam int unsigned BC_P_SQ_COEF   = 3038;
  localparam int          BC_P_LIN_COEF  = -7357;
  localparam int unsigned BC_P_OFFSET    = 3791;
  localparam int unsigned BC_PRES_MAX    = 262143;

  // side data carried through the temperature divider
  typedef struct packed {
    logic signed [18:0] x1;
    logic [BC_UP_W-1:0] up;
    logic               neg;
    logic               div0_t;
  } bc_side_t_t;

  // side data carried through the pressure divider
  typedef struct packed {
    logic                        big;
    logic signed [BC_TEMP_W-1:0] temp;
    logic                        div0_t;
    logic                        div0_p;
  } bc_side_p_t;

endpackage

`default_nettype wire

>>> rtl/barometer_compensation.sv
// ----------------------------------------------------------------------------
// barometer_compensation
// integer temperature and pressure compensation of a barometric sensor
// ----------------------------------------------------------------------------
// One word in carries a raw temperature UT and a raw pressure UP; one word out
// carries the temperature in 0.1 degC and the pressure in Pa, with a status
// flag in tuser that is set when a compensation divisor was zero (then the
// pressure reads 0, and the temperature too if the temperature divisor was
// zero). The block keeps nothing between words, so it takes one word every
// cycle and delivers one every cycle while the output is not stalled; the
// two bit-per-stage dividers (27 stages for the temperature step, 32 for the
// pressure step) sit among 16 arithmetic stages. The whole pipeline advances
// when the output register is empty or being taken, so in_tready follows
// out_tready. The user must write calibration words and the oversampling
// setting through the cfg port only while no word is in flight; the block
// does not enforce this. The cfg port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module barometer_compensation (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input words
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [bc_pkg::BC_IN_W-1:0]         in_tdata,   // raw_temperature, raw_pressure
  // result words
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [bc_pkg::BC_OUT_W-1:0]             out_tdata,  // temperature_tenths, pressure_pa
  output logic                                    out_tuser,  // status
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bc_pkg::BC_CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bc_pkg::BC_CFG_DATA_W-1:0]   cfg_data
);

  import bc_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] cal_temp_r;
  logic [63:0] cal_pres_a_r;
  logic [31:0] cal_pres_b_r;
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r   <= '0;
      cal_pres_a_r <= '0;
      cal_pres_b_r <= '0;
      oss_r        <= '0;
    end else if (cfg_valid) begin
      unique case (bc_reg_t'(cfg_index))
        BC_REG_CAL_TEMP:   cal_temp_r   <= cfg_data;
        BC_REG_CAL_PRES_A: cal_pres_a_r <= cfg_data;
        BC_REG_CAL_PRES_B: cal_pres_b_r <= cfg_data[31:0];
        BC_REG_OSS:        oss_r        <= cfg_data[1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // calibration coefficients
  logic        [15:0] ac4, ac5, ac6;
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;

  assign ac5 = cal_temp_r[15:0];
  assign ac6 = cal_temp_r[31:16];
  assign mc  = $signed(cal_temp_r[47:32]);
  assign md  = $signed(cal_temp_r[63:48]);
  assign ac1 = $signed(cal_pres_a_r[15:0]);
  assign ac2 = $signed(cal_pres_a_r[31:16]);
  assign ac3 = $signed(cal_pres_a_r[47:32]);
  assign ac4 = cal_pres_a_r[63:48];
  assign b1  = $signed(cal_pres_b_r[15:0]);
  assign b2  = $signed(cal_pres_b_r[31:16]);

  // --------------------------------------------------------------------------
  // pipeline advance: everything moves when the output register frees up
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic [BC_UT_W-1:0] in_ut;
  logic [BC_UP_W-1:0] in_up;

  assign in_ut = in_tdata[BC_UT_W-1:0];
  assign in_up = in_tdata[BC_UT_W+BC_UP_W-1:BC_UT_W];

  // --------------------------------------------------------------------------
  // s1: (UT - AC6) * AC5
  // --------------------------------------------------------------------------
  logic               s1_v_r;
  logic signed [33:0] s1_p1_r, s1_p1_nxt;
  logic [BC_UP_W-1:0] s1_up_r;
  logic signed [16:0] s1_diff;

  always_comb begin
    s1_diff   = $signed({1'b0, in_ut}) - $signed({1'b0, ac6});
    s1_p1_nxt = 34'(s1_diff) * $signed({18'b0, ac5});
  end

  // --------------------------------------------------------------------------
  // s2: X1, divisor X1+MD, operand magnitudes for the temperature divider
  // --------------------------------------------------------------------------
  logic               s2_v_r;
  bc_side_t_t         s2_side_r, s2_side_nxt;
  logic [26:0]        s2_num_r, s2_num_nxt;
  logic [17:0]        s2_den_r, s2_den_nxt;
  logic signed [18:0] s2_x1, s2_den;
  logic signed [18:0] s2_den_abs;
  logic signed [16:0] s2_mc_abs;

  always_comb begin
    s2_x1      = s1_p1_r[33:15];                      // floor shift by 15
    s2_den     = s2_x1 + 19'(md);
    s2_den_abs = s2_den[18] ? -s2_den : s2_den;
    s2_mc_abs  = mc[15] ? -17'(mc) : 17'(mc);
    s2_num_nxt = {s2_mc_abs[15:0], 11'b0};            // |MC| * 2048
    s2_den_nxt = s2_den_abs[17:0];
    s2_side_nxt.x1     = s2_x1;
    s2_side_nxt.up     = s1_up_r;
    s2_side_nxt.neg    = mc[15] ^ s2_den[18];
    s2_side_nxt.div0_t = (s2_den == '0);
  end

  // --------------------------------------------------------------------------
  // temperature divider: X2 = MC*2048 / (X1+MD), truncating
  // --------------------------------------------------------------------------
  logic                      d1_v;
  logic [BC_DIV_T_NUM_W-1:0] d1_q;
  logic [$bits(bc_side_t_t)-1:0] d1_side_raw;
  bc_side_t_t                d1_side;

  bc_div #(
    .NUM_W  (BC_DIV_T_NUM_W),
    .DEN_W  (BC_DIV_T_DEN_W),
    .SIDE_W ($bits(bc_side_t_t))
  ) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   (s2_side_r),
    .out_valid (d1_v),
    .out_quo   (d1_q),
    .out_side  (d1_side_raw)
  );

  assign d1_side = bc_side_t_t'(d1_side_raw);

  // --------------------------------------------------------------------------
  // e1: B5 = X1 + X2
  // --------------------------------------------------------------------------
  logic               e1_v_r;
  logic signed [28:0] e1_b5_r, e1_b5_nxt;
  logic [BC_UP_W-1:0] e1_up_r;
  logic               e1_div0t_r;
  logic signed [27:0] e1_x2;

  always_comb begin
    e1_x2     = d1_side.neg ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});
    e1_b5_nxt = 29'(d1_side.x1) + 29'(e1_x2);
  end

  // --------------------------------------------------------------------------
  // e2: B6 and saturated temperature
  // --------------------------------------------------------------------------
  logic                        e2_v_r;
  logic signed [28:0]          e2_b6_r, e2_b6_nxt;
  logic signed [BC_TEMP_W-1:0] e2_t_r, e2_t_nxt;
  logic [BC_UP_W-1:0]          e2_up_r;
  logic                        e2_div0t_r;
  logic signed [28:0]          e2_tr;

  always_comb begin
    e2_b6_nxt = e1_b5_r - 29'sd4000;
    e2_tr     = (e1_b5_r + 29'sd8) >>> 4;
    if (e2_tr > 29'sd32767) begin
      e2_t_nxt = 16'sh7fff;
    end else if (e2_tr < -29'sd32768) begin
      e2_t_nxt = 16'sh8000;
    end else begin
      e2_t_nxt = e2_tr[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // e3: B6^2, AC2*B6, AC3*B6
  // --------------------------------------------------------------------------
  logic                        e3_v_r;
  logic signed [57:0]          e3_sqp_r, e3_sqp_nxt;
  logic signed [44:0]          e3_pa2_r, e3_pa2_nxt;
  logic signed [44:0]          e3_pa3_r, e3_pa3_nxt;
  logic signed [BC_TEMP_W-1:0] e3_t_r;
  logic [BC_UP_W-1:0]          e3_up_r;
  logic                        e3_div0t_r;

  always_comb begin
    e3_sqp_nxt = 58'(e2_b6_r) * 58'(e2_b6_r);
    e3_pa2_nxt = 45'(ac2) * 45'(e2_b6_r);
    e3_pa3_nxt = 45'(ac3) * 45'(e2_b6_r);
  end

  // --------------------------------------------------------------------------
  // e4: scale the products
  // --------------------------------------------------------------------------
  logic                        e4_v_r;
  logic signed [45:0]          e4_sq_r, e4_sq_nxt;
  logic signed [33:0]          e4_x2a_r, e4_x2a_nxt;
  logic signed [31:0]          e4_x1c_r, e4_x1c_nxt;
  logic signed [BC_TEMP_W-1:0] e4_t_r;
  logic [BC_UP_W-1:0]          e4_up_r;
  logic                        e4_div0t_r;

  always_comb begin
    e4_sq_nxt  = e3_sqp_r[57:12];
    e4_x2a_nxt = e3_pa2_r[44:11];
    e4_x1c_nxt = e3_pa3_r[44:13];
  end

  // --------------------------------------------------------------------------
  // e5: B2*SQ, B1*SQ
  // --------------------------------------------------------------------------
  logic                        e5_v_r;
  logic signed [61:0]          e5_pb2_r, e5_pb2_nxt;
  logic signed [61:0]          e5_pb1_r, e5_pb1_nxt;
  logic signed [33:0]          e5_x2a_r;
  logic signed [31:0]          e5_x1c_r;
  logic signed [BC_TEMP_W-1:0] e5_t_r;
  logic [BC_UP_W-1:0]          e5_up_r;
  logic                        e5_div0t_r;

  always_comb begin
    e5_pb2_nxt = 62'(b2) * 62'(e4_sq_r);
    e5_pb1_nxt = 62'(b1) * 62'(e4_sq_r);
  end

  // --------------------------------------------------------------------------
  // e6: X3 for B3 and for B4
  // --------------------------------------------------------------------------
  logic                        e6_v_r;
  logic signed [51:0]          e6_x3a_r, e6_x3a_nxt;
  logic signed [44:0]          e6_x3c_r, e6_x3c_nxt;
  logic signed [BC_TEMP_W-1:0] e6_t_r;
  logic [BC_UP_W-1:0]          e6_up_r;
  logic                        e6_div0t_r;
  logic signed [46:0]          e6_sum;

  always_comb begin
    e6_x3a_nxt = 52'($signed(e5_pb2_r[61:11])) + 52'(e5_x2a_r);
    e6_sum     = 47'($signed(e5_pb1_r[61:16])) + 47'(e5_x1c_r) + 47'sd2;
    e6_x3c_nxt = e6_sum[46:2];
  end

  // --------------------------------------------------------------------------
  // e7: B3 (truncating /4), X3 + 32768 modulo 2^32
  // --------------------------------------------------------------------------
  logic                        e7_v_r;
  logic [31:0]                 e7_b3_r, e7_b3_nxt;
  logic [31:0]                 e7_u_r, e7_u_nxt;
  logic signed [BC_TEMP_W-1:0] e7_t_r;
  logic [BC_UP_W-1:0]          e7_up_r;
  logic                        e7_div0t_r;
  logic signed [52:0]          e7_base;
  logic signed [56:0]          e7_val;
  logic signed [56:0]          e7_b3;

  always_comb begin
    e7_base   = (53'(ac1) <<< 2) + 53'(e6_x3a_r);
    e7_val    = (57'(e7_base) <<< oss_r) + 57'sd2;
    e7_b3     = e7_val[56] ? ((e7_val + 57'sd3) >>> 2) : (e7_val >>> 2);
    e7_b3_nxt = e7_b3[31:0];
    e7_u_nxt  = e6_x3c_r[31:0] + 32'(BC_X3_OFFSET);
  end

  // --------------------------------------------------------------------------
  // e8: B4 = AC4 * (X3+32768) >> 15, UP - B3
  // --------------------------------------------------------------------------
  logic                        e8_v_r;
  logic [32:0]                 e8_b4_r, e8_b4_nxt;
  logic [31:0]                 e8_d_r, e8_d_nxt;
  logic signed [BC_TEMP_W-1:0] e8_t_r;
  logic                        e8_div0t_r;
  logic [47:0]                 e8_prod;

  always_comb begin
    e8_prod   = 48'(ac4) * 48'(e7_u_r);
    e8_b4_nxt = e8_prod[47:15];
    e8_d_nxt  = 32'(e7_up_r) - e7_b3_r;
  end

  // --------------------------------------------------------------------------
  // e9: B7 = (UP - B3) * (50000 >> oss) modulo 2^32
  // --------------------------------------------------------------------------
  logic                        e9_v_r;
  logic [31:0]                 e9_b7_r, e9_b7_nxt;
  logic [32:0]                 e9_b4_r;
  logic                        e9_b4z_r, e9_b4z_nxt;
  logic signed [BC_TEMP_W-1:0] e9_t_r;
  logic                        e9_div0t_r;
  logic [15:0]                 e9_fac;
  logic [47:0]                 e9_prod;

  always_comb begin
    e9_fac     = 16'(BC_P_FACTOR >> oss_r);
    e9_prod    = 48'(e8_d_r) * 48'(e9_fac);
    e9_b7_nxt  = e9_prod[31:0];
    e9_b4z_nxt = (e8_b4_r == '0);
  end

  // --------------------------------------------------------------------------
  // pressure divider: 2*B7/B4 below 2^31, (B7/B4)*2 above
  // --------------------------------------------------------------------------
  logic                      d2_v;
  logic [BC_DIV_P_NUM_W-1:0] d2_q;
  logic [$bits(bc_side_p_t)-1:0] d2_side_raw;
  bc_side_p_t                d2_side;
  bc_side_p_t                d2_side_in;
  logic [BC_DIV_P_NUM_W-1:0] d2_num;

  always_comb begin
    d2_side_in.big    = e9_b7_r[31];
    d2_side_in.temp   = e9_t_r;
    d2_side_in.div0_t = e9_div0t_r;
    d2_side_in.div0_p = e9_b4z_r;
    d2_num = e9_b7_r[31] ? e9_b7_r : {e9_b7_r[30:0], 1'b0};
  end

  bc_div #(
    .NUM_W  (BC_DIV_P_NUM_W),
    .DEN_W  (BC_DIV_P_DEN_W),
    .SIDE_W ($bits(bc_side_p_t))
  ) u_div_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e9_v_r),
    .in_num    (d2_num),
    .in_den    (e9_b4_r),
    .in_side   (d2_side_in),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_side  (d2_side_raw)
  );

  assign d2_side = bc_side_p_t'(d2_side_raw);

  // --------------------------------------------------------------------------
  // f1: undo the halving for large B7
  // --------------------------------------------------------------------------
  logic        f1_v_r;
  logic [32:0] f1_p_r, f1_p_nxt;
  bc_side_p_t  f1_side_r;

  assign f1_p_nxt = d2_side.big ? {d2_q, 1'b0} : {1'b0, d2_q};

  // --------------------------------------------------------------------------
  // f2: (p>>8)^2 and -7357*p
  // --------------------------------------------------------------------------
  logic               f2_v_r;
  logic [32:0]        f2_p_r;
  logic [49:0]        f2_sqr_r, f2_sqr_nxt;
  logic signed [47:0] f2_m2_r, f2_m2_nxt;
  bc_side_p_t         f2_side_r;

  always_comb begin
    f2_sqr_nxt = 50'(f1_p_r[32:8]) * 50'(f1_p_r[32:8]);
    f2_m2_nxt  = 48'(BC_P_LIN_COEF) * $signed({15'b0, f1_p_r});
  end

  // --------------------------------------------------------------------------
  // f3: X1 = sq * 3038 >> 16, X2 = m >> 16
  // --------------------------------------------------------------------------
  logic               f3_v_r;
  logic [32:0]        f3_p_r;
  logic [45:0]        f3_x1_r, f3_x1_nxt;
  logic signed [31:0] f3_x2_r, f3_x2_nxt;
  bc_side_p_t         f3_side_r;
  logic [61:0]        f3_prod;

  always_comb begin
    f3_prod   = 62'(f2_sqr_r) * 62'(BC_P_SQ_COEF);
    f3_x1_nxt = f3_prod[61:16];
    f3_x2_nxt = f2_m2_r[47:16];
  end

  // --------------------------------------------------------------------------
  // f4: p + (X1 + X2 + 3791) >> 4
  // --------------------------------------------------------------------------
  logic               f4_v_r;
  logic signed [47:0] f4_pf_r, f4_pf_nxt;
  bc_side_p_t         f4_side_r;
  logic signed [47:0] f4_sum;

  always_comb begin
    f4_sum    = $signed({2'b0, f3_x1_r}) + 48'(f3_x2_r) + 48'(BC_P_OFFSET);
    f4_pf_nxt = $signed({15'b0, f3_p_r}) + (f4_sum >>> 4);
  end

  // --------------------------------------------------------------------------
  // output register: saturation and divide-by-zero override
  // --------------------------------------------------------------------------
  logic signed [BC_TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [BC_PRES_W-1:0]        out_pres_r, out_pres_nxt;
  logic                        out_stat_r, out_stat_nxt;

  always_comb begin
    out_temp_nxt = f4_side_r.temp;
    out_stat_nxt = 1'b0;
    if (f4_pf_r < 48'sd0) begin
      out_pres_nxt = '0;
    end else if (f4_pf_r > 48'(BC_PRES_MAX)) begin
      out_pres_nxt = BC_PRES_W'(BC_PRES_MAX);
    end else begin
      out_pres_nxt = f4_pf_r[BC_PRES_W-1:0];
    end
    if (f4_side_r.div0_t) begin
      out_temp_nxt = '0;
      out_pres_nxt = '0;
      out_stat_nxt = 1'b1;
    end else if (f4_side_r.div0_p) begin
      out_pres_nxt = '0;
      out_stat_nxt = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // valid chain
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      e1_v_r      <= 1'b0;
      e2_v_r      <= 1'b0;
      e3_v_r      <= 1'b0;
      e4_v_r      <= 1'b0;
      e5_v_r      <= 1'b0;
      e6_v_r      <= 1'b0;
      e7_v_r      <= 1'b0;
      e8_v_r      <= 1'b0;
      e9_v_r      <= 1'b0;
      f1_v_r      <= 1'b0;
      f2_v_r      <= 1'b0;
      f3_v_r      <= 1'b0;
      f4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_tvalid;
      s2_v_r      <= s1_v_r;
      e1_v_r      <= d1_v;
      e2_v_r      <= e1_v_r;
      e3_v_r      <= e2_v_r;
      e4_v_r      <= e3_v_r;
      e5_v_r      <= e4_v_r;
      e6_v_r      <= e5_v_r;
      e7_v_r      <= e6_v_r;
      e8_v_r      <= e7_v_r;
      e9_v_r      <= e8_v_r;
      f1_v_r      <= d2_v;
      f2_v_r      <= f1_v_r;
      f3_v_r      <= f2_v_r;
      f4_v_r      <= f3_v_r;
      out_valid_r <= f4_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p1_r    <= s1_p1_nxt;
      s1_up_r    <= in_up;
      s2_side_r  <= s2_side_nxt;
      s2_num_r   <= s2_num_nxt;
      s2_den_r   <= s2_den_nxt;
      e1_b5_r    <= e1_b5_nxt;
      e1_up_r    <= d1_side.up;
      e1_div0t_r <= d1_side.div0_t;
      e2_b6_r    <= e2_b6_nxt;
      e2_t_r     <= e2_t_nxt;
      e2_up_r    <= e1_up_r;
      e2_div0t_r <= e1_div0t_r;
      e3_sqp_r   <= e3_sqp_nxt;
      e3_pa2_r   <= e3_pa2_nxt;
      e3_pa3_r   <= e3_pa3_nxt;
      e3_t_r     <= e2_t_r;
      e3_up_r    <= e2_up_r;
      e3_div0t_r <= e2_div0t_r;
      e4_sq_r    <= e4_sq_nxt;
      e4_x2a_r   <= e4_x2a_nxt;
      e4_x1c_r   <= e4_x1c_nxt;
      e4_t_r     <= e3_t_r;
      e4_up_r    <= e3_up_r;
      e4_div0t_r <= e3_div0t_r;
      e5_pb2_r   <= e5_pb2_nxt;
      e5_pb1_r   <= e5_pb1_nxt;
      e5_x2a_r   <= e4_x2a_r;
      e5_x1c_r   <= e4_x1c_r;
      e5_t_r     <= e4_t_r;
      e5_up_r    <= e4_up_r;
      e5_div0t_r <= e4_div0t_r;
      e6_x3a_r   <= e6_x3a_nxt;
      e6_x3c_r   <= e6_x3c_nxt;
      e6_t_r     <= e5_t_r;
      e6_up_r    <= e5_up_r;
      e6_div0t_r <= e5_div0t_r;
      e7_b3_r    <= e7_b3_nxt;
      e7_u_r     <= e7_u_nxt;
      e7_t_r     <= e6_t_r;
      e7_up_r    <= e6_up_r;
      e7_div0t_r <= e6_div0t_r;
      e8_b4_r    <= e8_b4_nxt;
      e8_d_r     <= e8_d_nxt;
      e8_t_r     <= e7_t_r;
      e8_div0t_r <= e7_div0t_r;
      e9_b7_r    <= e9_b7_nxt;
      e9_b4_r    <= e8_b4_r;
      e9_b4z_r   <= e9_b4z_nxt;
      e9_t_r     <= e8_t_r;
      e9_div0t_r <= e8_div0t_r;
      f1_p_r     <= f1_p_nxt;
      f1_side_r  <= d2_side;
      f2_p_r     <= f1_p_r;
      f2_sqr_r   <= f2_sqr_nxt;
      f2_m2_r    <= f2_m2_nxt;
      f2_side_r  <= f1_side_r;
      f3_p_r     <= f2_p_r;
      f3_x1_r    <= f3_x1_nxt;
      f3_x2_r    <= f3_x2_nxt;
      f3_side_r  <= f2_side_r;
      f4_pf_r    <= f4_pf_nxt;
      f4_side_r  <= f3_side_r;
      out_temp_r <= out_temp_nxt;
      out_pres_r <= out_pres_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_pres_r, out_temp_r};
  assign out_tuser  = out_stat_r;

endmodule

`default_nettype wire

>>> rtl/bc_div.sv
// ----------------------------------------------------------------------------
// bc_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module bc_div #(
  parameter int NUM_W  = bc_pkg::BC_DIV_T_NUM_W,
  parameter int DEN_W  = bc_pkg::BC_DIV_T_DEN_W,
  parameter int SIDE_W = $bits(bc_pkg::bc_side_t_t)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  num_r  [NUM_W];
  logic [NUM_W-1:0]  quo_r  [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  num_in;
    logic [NUM_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign num_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_in, num_in[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        num_r[k]  <= num_in << 1;
        quo_r[k]  <= {quo_in[NUM_W-2:0], fits};
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = quo_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/bc_checker.sv
// ----------------------------------------------------------------------------
// bc_checker
// port-level checks of the barometer compensation block
// ----------------------------------------------------------------------------
`default_nettype none

module bc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [bc_pkg::BC_OUT_W-1:0]      out_tdata,
  input wire logic                             out_tuser
);

  import bc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed under stall");

  // pipeline takes input exactly when the output side moves
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // a flagged result carries no pressure
  a_status_pres: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[BC_TEMP_W+BC_PRES_W-1:BC_TEMP_W] == '0)
    else $error("pressure nonzero on divide-by-zero result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind barometer_compensation bc_checker u_bc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> tb/barometer_compensation_checker.sv
// ----------------------------------------------------------------------------
// barometer_compensation_checker
// watches the input, result and configuration channels of the compensation
// block, predicts each result word from the raw readings and the calibration
// copy it keeps, and compares result words field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module barometer_compensation_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               results_seen,
  output int               div0_seen
);
  import bc_pkg::*;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [17:0]        pres;
    logic               status;
  } comp_result_t;

  logic [63:0] cal_t, cal_pa;
  logic [31:0] cal_pb;
  logic [1:0]  oss_r;
  comp_result_t expected_q[$];

  function automatic longint s16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // floor shift on 64-bit signed values
  function automatic longint fsr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic comp_result_t compensate(logic [15:0] ut_in, logic [18:0] up_in);
    comp_result_t r;
    longint ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2, ut;
    longint x1, x2, x3, b3, b4, b5, b6, sq, t, p;
    logic [31:0] b7, x3w;
    logic [63:0] prod;
    ac5 = longint'(cal_t[15:0]);  ac6 = longint'(cal_t[31:16]);
    mc = s16(cal_t[47:32]);       md = s16(cal_t[63:48]);
    ac1 = s16(cal_pa[15:0]);      ac2 = s16(cal_pa[31:16]);
    ac3 = s16(cal_pa[47:32]);     ac4 = longint'(cal_pa[63:48]);
    b1 = s16(cal_pb[15:0]);       b2 = s16(cal_pb[31:16]);
    ut = longint'(ut_in);
    r = '0;
    x1 = fsr((ut - ac6) * ac5, 15);
    if (x1 + md == 0) begin
      r.status = 1'b1;
      return r;
    end
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t = fsr(b5 + 8, 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    r.temp = t[15:0];
    b6 = b5 - 4000;
    sq = fsr(b6 * b6, 12);
    x1 = fsr(b2 * sq, 11);
    x2 = fsr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_r) + 2) / 4;
    x1 = fsr(ac3 * b6, 13);
    x2 = fsr(b1 * sq, 16);
    x3 = fsr(x1 + x2 + 2, 2);
    x3w = 32'(x3 + 32768);
    prod = 64'(ac4) * 64'(x3w);
    b4 = longint'(prod >> 15);
    if (b4 == 0) begin
      r.status = 1'b1;
      return r;
    end
    b7 = 32'((32'(longint'(up_in) - b3)) * (32'd50000 >> oss_r));
    if (b7 < 32'h8000_0000) p = (longint'(b7) * 2) / b4;
    else p = (longint'(b7) / b4) * 2;
    x1 = (p >>> 8) * (p >>> 8);
    x1 = fsr(x1 * 3038, 16);
    x2 = fsr(-7357 * p, 16);
    p = p + fsr(x1 + x2 + 3791, 4);
    if (p < 0) p = 0;
    if (p > 262143) p = 262143;
    r.pres = p[17:0];
    return r;
  endfunction

  always @(posedge clk) begin
    comp_result_t e, a;
    if (!rst_n) begin
      cal_t <= '0; cal_pa <= '0; cal_pb <= '0; oss_r <= '0;
      fail_count <= 0; pending <= 0; results_seen <= 0; div0_seen <= 0;
      expected_q.delete();
    end else begin
      // configuration copy
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          BC_REG_CAL_TEMP:   cal_t  <= cfg_data;
          BC_REG_CAL_PRES_A: cal_pa <= cfg_data;
          BC_REG_CAL_PRES_B: cal_pb <= cfg_data[31:0];
          BC_REG_OSS:        oss_r  <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(compensate(in_tdata[15:0], in_tdata[34:16]));
      if (out_tvalid && out_tready) begin
        a.temp = out_tdata[15:0];
        a.pres = out_tdata[33:16];
        a.status = out_tuser;
        results_seen <= results_seen + 1;
        if (a.status) div0_seen <= div0_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result word temp=%0d pres=%0d status=%0b",
                     $realtime, a.temp, a.pres, a.status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != a) begin
            if (fail_count < 10)
              $display("%0t: mismatch temp exp %0d got %0d, pres exp %0d got %0d, status exp %0b got %0b",
                       $realtime, e.temp, a.temp, e.pres, a.pres, e.status, a.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

>>> tb/barometer_compensation_tb.sv
// ----------------------------------------------------------------------------
// barometer_compensation_tb
// stimulus and verdict for the barometer compensation block
// ----------------------------------------------------------------------------
// Drives raw readings under several calibration sets (typical sensor values,
// all-zero, all-ones, random, divisor-zero cases) and every oversampling
// setting, with random idling on both sides. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module barometer_compensation_tb;
  import bc_pkg::*;

  localparam int LATENCY   = 75;
  localparam int WD_LIMIT  = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int fail_count, pending, results_seen, div0_seen;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int idle_cycles = 0;
  int words_sent = 0;
  bit timed_out = 1'b0;

  always #1 clk = ~clk;

  barometer_compensation dut (.*);

  barometer_compensation_checker checker_i (.*);

  // receiver stall
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic cfg_write(bc_reg_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until the pipeline has drained every expected result word
  task automatic drain();
    @(posedge clk);
    while (pending != 0 || out_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cal(logic [63:0] ct, logic [63:0] cpa, logic [31:0] cpb,
                          logic [1:0] oss);
    drain();
    cfg_write(BC_REG_CAL_TEMP, ct);
    cfg_write(BC_REG_CAL_PRES_A, cpa);
    cfg_write(BC_REG_CAL_PRES_B, {32'h0, cpb});
    cfg_write(BC_REG_OSS, {62'h0, oss});
  endtask

  // one reading; valid stays high across back-to-back words
  task automatic send_reading(logic [15:0] ut, logic [18:0] up);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, up, ut};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // typical sensor calibration, randomly perturbed
  function automatic logic [63:0] typ_t();
    logic [15:0] ac5, ac6, mc, md;
    ac5 = 16'd24000 + 16'($urandom_range(2000));
    ac6 = 16'd17000 + 16'($urandom_range(3000));
    mc  = 16'(-11786 + int'($urandom_range(1000)));
    md  = 16'd2000 + 16'($urandom_range(1500));
    return {md, mc, ac6, ac5};
  endfunction

  function automatic logic [63:0] typ_pa();
    logic [15:0] ac1, ac2, ac3, ac4;
    ac1 = 16'd7000 + 16'($urandom_range(2000));
    ac2 = 16'(-1300 + int'($urandom_range(500)));
    ac3 = 16'(-15000 + int'($urandom_range(2000)));
    ac4 = 16'd31000 + 16'($urandom_range(4000));
    return {ac4, ac3, ac2, ac1};
  endfunction

  function automatic logic [31:0] typ_pb();
    logic [15:0] b1, b2;
    b1 = 16'd6000 + 16'($urandom_range(1000));
    b2 = 16'd30 + 16'($urandom_range(40));
    return {b2, b1};
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count);
    logic [1:0] oss;
    for (int i = 0; i < count; i++) begin
      // switch calibration now and then; mostly realistic, sometimes wild
      if (i % 60 == 0) begin
        stop_sending();
        oss = 2'($urandom_range(3));
        case ($urandom_range(9))
          0:       load_cal(rnd64(), rnd64(), $urandom, oss);
          // md zero
          1:       load_cal(rnd64() & 64'h0000_FFFF_FFFF_FFFF, rnd64(), $urandom, oss);
          // ac4 zero
          2:       load_cal(typ_t(), typ_pa() & 64'h0000_FFFF_FFFF_FFFF, typ_pb(), oss);
          default: load_cal(typ_t(), typ_pa(), typ_pb(), oss);
        endcase
      end
      if ($urandom_range(3) == 0)
        send_reading(16'($urandom), 19'($urandom));
      else
        send_reading(16'd25000 + 16'($urandom_range(10000)),
                     19'(($urandom_range(20000) + 15000) << (3 - $urandom_range(3))));
    end
    stop_sending();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset calibration (divisor zero), then extremes
    send_reading(16'h0000, 19'h00000);
    send_reading(16'hFFFF, 19'h7FFFF);
    stop_sending();
    load_cal({16'd2868, 16'hD1F6, 16'd15724, 16'd32757},
             {16'd32741, 16'hC7A6, 16'hFFB8, 16'd408}, {16'd4, 16'd6190}, 2'd0);
    send_reading(16'd27898, 19'd23843);
    send_reading(16'h0000, 19'h00000);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'hFFFF, 19'h00000);
    send_reading(16'h0000, 19'h7FFFF);
    stop_sending();
    load_cal({64{1'b1}}, {64{1'b1}}, 32'hFFFF_FFFF, 2'd3);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'h5555, 19'h2AAAA);
    send_reading(16'hAAAA, 19'h55555);
    stop_sending();
    load_cal({16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF},
             {16'h0001, 16'h8000, 16'h7FFF, 16'h8000}, 32'h8000_7FFF, 2'd1);
    send_reading(16'h0000, 19'h7FFFF);
    send_reading(16'hFFFF, 19'h00000);
    stop_sending();
    load_cal({16'd2000, 16'hD1F6, 16'd17000, 16'd24000},
             typ_pa() & 64'h0000_FFFF_FFFF_FFFF, typ_pb(), 2'd2);
    send_reading(16'd27000, 19'd90000);
    stop_sending();

    send_idle_pct = 17; recv_idle_pct = 76;
    random_phase(420);
    send_idle_pct = 76; recv_idle_pct = 17;
    random_phase(420);
    // sender holds until the pipeline is empty, then bursts
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(400);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d readings, checked %0d results (%0d flagged divide-by-zero)",
             words_sent, results_seen, div0_seen);
    $display("calibration sets covered typical, zero, all-ones, random and every oss");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bc_pkg.sv
rtl/bc_div.sv
rtl/barometer_compensation.sv
rtl/bc_checker.sv
tb/barometer_compensation_checker.sv
tb/barometer_compensation_tb.sv
